// ----- src/fld_pkg.sv -----
package fld_pkg;

  // Sample widths
  localparam int ACCEL_BITS = 16;
  localparam int SQ_W       = 2 * ACCEL_BITS;
  localparam int SUM_W      = SQ_W + 2;
  localparam int MAG_W      = 32;
  localparam int VEL_W      = 32;
  localparam int TIME_W     = 64;
  localparam int HOLD_W     = 32;

  // Register port
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 5;
  localparam int IDX_W      = 3;

  // Queue between classifier and qualifier
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [63:0] MAG_MAX = 64'h0000_0000_FFFF_FFFF;

  // Register map, one word each
  typedef enum logic [IDX_W-1:0] {
    REG_FALL_ACCEL  = 3'd0,
    REG_FALL_VEL    = 3'd1,
    REG_LANDED_ACCEL = 3'd2,
    REG_LANDED_VEL  = 3'd3,
    REG_FALL_HOLD   = 3'd4,
    REG_LANDED_HOLD = 3'd5
  } reg_idx_t;

  // Reset values: 0.4 g and 0.9 g squared at 2048 counts per g
  localparam logic [MAG_W-1:0]         RST_FALL_ACCEL   = 32'd671089;
  localparam logic signed [VEL_W-1:0]  RST_FALL_VEL     = 32'sd100;
  localparam logic [MAG_W-1:0]         RST_LANDED_ACCEL = 32'd3397386;
  localparam logic signed [VEL_W-1:0]  RST_LANDED_VEL   = 32'sd5;
  localparam logic [HOLD_W-1:0]        RST_FALL_HOLD    = 32'd1000000;
  localparam logic [HOLD_W-1:0]        RST_LANDED_HOLD  = 32'd1000000;

  typedef struct packed {
    logic [MAG_W-1:0]        fall_accel_sq_limit;
    logic signed [VEL_W-1:0] fall_velocity_limit;
    logic [MAG_W-1:0]        landed_accel_sq_limit;
    logic signed [VEL_W-1:0] landed_velocity_limit;
    logic [HOLD_W-1:0]       fall_hold_us;
    logic [HOLD_W-1:0]       landed_hold_us;
  } fld_cfg_t;

  // Classified sample handed from front to back
  typedef struct packed {
    logic              fall_cond;
    logic              land_cond;
    logic [MAG_W-1:0]  mag;
    logic [TIME_W-1:0] time_us;
  } fld_item_t;

endpackage

// ----- src/freefall_landing_detector.sv -----
// Channel  | Ports                                         | Handshake
// ---------+-----------------------------------------------+-------------------
// input    | in_accel_x/y/z, in_down_velocity, in_time_us  | in_valid/in_stall
// result   | out_falling, out_landed, out_accel_mag_sq     | out_valid/out_stall
// config   | psel penable pwrite paddr pwdata prdata pready| APB write, pready=1
//
// One beat per cycle sustained while out_stall is low; a beat passes through
// the square stage, the four-entry queue and the qualifier output register.
// Synchronous reset clears flags, candidates, queue and output, and loads the
// register defaults.
// out_stall holds the output register; with the four-entry queue and the
// square stage filling behind it, six beats are taken before in_stall rises.
module freefall_landing_detector (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [fld_pkg::ACCEL_BITS-1:0]  in_accel_x,
  input  logic signed [fld_pkg::ACCEL_BITS-1:0]  in_accel_y,
  input  logic signed [fld_pkg::ACCEL_BITS-1:0]  in_accel_z,
  input  logic signed [fld_pkg::VEL_W-1:0]       in_down_velocity,
  input  logic [fld_pkg::TIME_W-1:0]             in_time_us,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_falling,
  output logic                                   out_landed,
  output logic [fld_pkg::MAG_W-1:0]              out_accel_mag_sq,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [fld_pkg::ADDR_W-1:0]             paddr,
  input  logic [fld_pkg::DATA_W-1:0]             pwdata,
  output logic [fld_pkg::DATA_W-1:0]             prdata,
  output logic                                   pready
);
  import fld_pkg::*;

  fld_cfg_t   cfg_r;
  reg_idx_t   reg_idx;
  logic       wr_en;
  logic       q_push, q_full, q_pop, q_empty;
  fld_item_t  q_in, q_head;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fall_accel_sq_limit   <= RST_FALL_ACCEL;
      cfg_r.fall_velocity_limit   <= RST_FALL_VEL;
      cfg_r.landed_accel_sq_limit <= RST_LANDED_ACCEL;
      cfg_r.landed_velocity_limit <= RST_LANDED_VEL;
      cfg_r.fall_hold_us          <= RST_FALL_HOLD;
      cfg_r.landed_hold_us        <= RST_LANDED_HOLD;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FALL_ACCEL:   cfg_r.fall_accel_sq_limit   <= pwdata;
        REG_FALL_VEL:     cfg_r.fall_velocity_limit   <= signed'(pwdata);
        REG_LANDED_ACCEL: cfg_r.landed_accel_sq_limit <= pwdata;
        REG_LANDED_VEL:   cfg_r.landed_velocity_limit <= signed'(pwdata);
        REG_FALL_HOLD:    cfg_r.fall_hold_us          <= pwdata;
        REG_LANDED_HOLD:  cfg_r.landed_hold_us        <= pwdata;
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      REG_FALL_ACCEL:   prdata = cfg_r.fall_accel_sq_limit;
      REG_FALL_VEL:     prdata = cfg_r.fall_velocity_limit;
      REG_LANDED_ACCEL: prdata = cfg_r.landed_accel_sq_limit;
      REG_LANDED_VEL:   prdata = cfg_r.landed_velocity_limit;
      REG_FALL_HOLD:    prdata = cfg_r.fall_hold_us;
      REG_LANDED_HOLD:  prdata = cfg_r.landed_hold_us;
      default:          prdata = '0;
    endcase
  end

  fld_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .accel_x       (in_accel_x),
    .accel_y       (in_accel_y),
    .accel_z       (in_accel_z),
    .down_velocity (in_down_velocity),
    .time_us       (in_time_us),
    .cfg           (cfg_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in)
  );

  fld_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  fld_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_falling      (out_falling),
    .out_landed       (out_landed),
    .out_accel_mag_sq (out_accel_mag_sq)
  );

endmodule

// ----- src/fld_front.sv -----
module fld_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [fld_pkg::ACCEL_BITS-1:0] accel_x,
  input  logic signed [fld_pkg::ACCEL_BITS-1:0] accel_y,
  input  logic signed [fld_pkg::ACCEL_BITS-1:0] accel_z,
  input  logic signed [fld_pkg::VEL_W-1:0]    down_velocity,
  input  logic [fld_pkg::TIME_W-1:0]          time_us,
  input  fld_pkg::fld_cfg_t                   cfg,
  input  logic                                q_full,
  output logic                                q_push,
  output fld_pkg::fld_item_t                  q_item
);
  import fld_pkg::*;

  logic              s1_valid_r;
  logic [SQ_W-1:0]   sq_x_r, sq_y_r, sq_z_r;
  logic signed [VEL_W-1:0] vel_r;
  logic [TIME_W-1:0] time_r;

  logic [SQ_W-1:0]   sq_x, sq_y, sq_z;
  logic              advance;
  logic [SUM_W-1:0]  sum;
  logic              sat;
  logic [MAG_W-1:0]  mag;

  // Square each axis; product of a value with itself is never negative
  assign sq_x = SQ_W'(accel_x) * SQ_W'(accel_x);
  assign sq_y = SQ_W'(accel_y) * SQ_W'(accel_y);
  assign sq_z = SQ_W'(accel_z) * SQ_W'(accel_z);

  assign advance  = !s1_valid_r || !q_full;
  assign in_stall = !advance;
  assign q_push   = s1_valid_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      sq_x_r <= sq_x;
      sq_y_r <= sq_y;
      sq_z_r <= sq_z;
      vel_r  <= down_velocity;
      time_r <= time_us;
    end
  end

  // Magnitude sum, saturated to 32 bits
  assign sum = SUM_W'(sq_x_r) + SUM_W'(sq_y_r) + SUM_W'(sq_z_r);
  assign sat = sum > SUM_W'(MAG_MAX);
  assign mag = sat ? '1 : MAG_W'(sum);

  // Classify against both threshold pairs
  always_comb begin
    q_item.mag       = mag;
    q_item.time_us   = time_r;
    q_item.fall_cond = (mag <= cfg.fall_accel_sq_limit) ||
                       (vel_r >= cfg.fall_velocity_limit);
    q_item.land_cond = (mag >= cfg.landed_accel_sq_limit) ||
                       (vel_r <= cfg.landed_velocity_limit);
  end

endmodule

// ----- src/fld_queue.sv -----
module fld_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fld_pkg::fld_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output fld_pkg::fld_item_t head
);
  import fld_pkg::*;

  fld_item_t         entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = entries_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- src/fld_back.sv -----
module fld_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fld_pkg::fld_cfg_t          cfg,
  input  logic                       q_empty,
  input  fld_pkg::fld_item_t         q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_falling,
  output logic                       out_landed,
  output logic [fld_pkg::MAG_W-1:0]  out_accel_mag_sq
);
  import fld_pkg::*;

  logic              falling_r, landed_r;
  logic              fs_valid_r, ls_valid_r;
  logic [TIME_W-1:0] fs_time_r, ls_time_r;
  logic              out_valid_r;
  logic              out_falling_r, out_landed_r;
  logic [MAG_W-1:0]  out_mag_r;

  logic              falling_nxt, landed_nxt;
  logic              fs_valid_nxt, ls_valid_nxt;
  logic [TIME_W-1:0] fs_time_nxt, ls_time_nxt;

  logic [TIME_W-1:0] start_sel;
  logic [HOLD_W-1:0] hold_sel;
  logic [TIME_W:0]   elapsed;
  logic              held;

  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  // One shared elapsed-time check: fall stage before falling, land stage after
  assign start_sel = falling_r ? ls_time_r : fs_time_r;
  assign hold_sel  = falling_r ? cfg.landed_hold_us : cfg.fall_hold_us;
  assign elapsed   = {1'b0, q_head.time_us} - {1'b0, start_sel};
  // borrow means time went backwards: elapsed counts as zero
  assign held      = !elapsed[TIME_W] &&
                     (elapsed[TIME_W-1:0] > TIME_W'(hold_sel));

  // Qualification state update for the head beat
  always_comb begin
    falling_nxt  = falling_r;
    landed_nxt   = landed_r;
    fs_valid_nxt = fs_valid_r;
    ls_valid_nxt = ls_valid_r;
    fs_time_nxt  = fs_time_r;
    ls_time_nxt  = ls_time_r;
    if (!falling_r) begin
      if (!q_head.fall_cond) begin
        fs_valid_nxt = 1'b0;
      end else if (!fs_valid_r) begin
        fs_valid_nxt = 1'b1;
        fs_time_nxt  = q_head.time_us;
      end else if (held) begin
        falling_nxt = 1'b1;
      end
    end else begin
      if (!q_head.land_cond) begin
        ls_valid_nxt = 1'b0;
      end else if (!ls_valid_r) begin
        ls_valid_nxt = 1'b1;
        ls_time_nxt  = q_head.time_us;
      end else if (held) begin
        landed_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      falling_r   <= 1'b0;
      landed_r    <= 1'b0;
      fs_valid_r  <= 1'b0;
      ls_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        falling_r  <= falling_nxt;
        landed_r   <= landed_nxt;
        fs_valid_r <= fs_valid_nxt;
        ls_valid_r <= ls_valid_nxt;
      end
      if (q_pop)           out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Start times and the output beat
  always_ff @(posedge clk) begin
    if (q_pop) begin
      fs_time_r     <= fs_time_nxt;
      ls_time_r     <= ls_time_nxt;
      out_falling_r <= falling_nxt;
      out_landed_r  <= landed_nxt;
      out_mag_r     <= q_head.mag;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_falling      = out_falling_r;
  assign out_landed       = out_landed_r;
  assign out_accel_mag_sq = out_mag_r;

endmodule

// ----- src/fld_checker.sv -----
module fld_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_falling,
  input logic                       out_landed,
  input logic [fld_pkg::MAG_W-1:0]  out_accel_mag_sq
);
  import fld_pkg::*;

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_falling) &&
    $stable(out_landed) && $stable(out_accel_mag_sq))
    else $error("stalled result beat changed");

  // Landing is only ever reported after a fall
  a_land_after_fall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_landed |-> out_falling)
    else $error("landed without falling");

  // Falling flag latches across taken beats
  a_fall_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_falling |=> !out_valid || out_falling)
    else $error("falling flag dropped");

  // Landed flag latches across taken beats
  a_land_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_landed |=> !out_valid || out_landed)
    else $error("landed flag dropped");

endmodule

bind freefall_landing_detector fld_checker u_fld_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_falling      (out_falling),
  .out_landed       (out_landed),
  .out_accel_mag_sq (out_accel_mag_sq)
);
